// ===== rtl/jrss_pkg.sv =====
// Shared types and constants for the joint ramp scan sequencer.
package jrss_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PUT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_TO_START = 2'd1,
        PH_SCAN     = 2'd2,
        PH_MOVE     = 2'd3
    } t_phase;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SCAN = 2'd1;
    localparam logic [1:0] OP_MOVE = 2'd2;

    localparam int          REG_WIDTH         = 16;
    localparam logic [1:0]  ADDR_MOVE_TICKS   = 2'd0;
    localparam logic [15:0] MOVE_TICKS_RESET  = 16'd500;

endpackage

// ===== rtl/jrss_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module jrss_mul #(
    parameter int AW = 16,
    parameter int CW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_mcand,
    input  logic [CW-1:0]    i_mplr,
    output logic             o_done,
    output logic [AW+CW-1:0] o_product
);
    import jrss_pkg::*;

    localparam int SW = $clog2(CW);

    logic [AW-1:0] r_mcand, n_mcand;
    logic [AW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_lo, n_lo;
    logic [SW-1:0] r_step, n_step;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [AW:0]   sum;

    always_comb begin
        n_mcand = r_mcand;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        sum     = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);
        if (i_start) begin
            n_mcand = i_mcand;
            n_hi    = '0;
            n_lo    = i_mplr;
            n_step  = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            // add-and-shift right: low bits of the product fill in from the top
            n_hi   = sum[AW:1];
            n_lo   = {sum[0], r_lo[CW-1:1]};
            n_step = r_step + 1'b1;
            if (r_step == SW'(CW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand <= n_mcand;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_step  <= n_step;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

// ===== rtl/jrss_div.sv =====
// Restoring divider: one quotient bit per cycle, unsigned operands.
module jrss_div #(
    parameter int DW = 32,
    parameter int CW = 16,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [QW-1:0] o_quotient
);
    import jrss_pkg::*;

    localparam int SW = $clog2(DW);

    logic [DW-1:0] r_dvd, n_dvd;
    logic [CW-1:0] r_dvsr, n_dvsr;
    logic [CW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_step, n_step;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          fits;

    always_comb begin
        n_dvd  = r_dvd;
        n_dvsr = r_dvsr;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_dvd[DW-1]};
        diff   = trial - {1'b0, r_dvsr};
        fits   = trial >= {1'b0, r_dvsr};
        if (i_start) begin
            n_dvd  = i_dividend;
            n_dvsr = i_divisor;
            n_rem  = '0;
            n_quo  = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits in CW bits
            n_rem  = fits ? diff[CW-1:0] : trial[CW-1:0];
            n_quo  = {r_quo[QW-2:0], fits};
            n_dvd  = {r_dvd[DW-2:0], 1'b0};
            n_step = r_step + 1'b1;
            if (r_step == SW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_dvsr <= n_dvsr;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/joint_ramp_scan_sequencer.sv =====
// Joint ramp scan sequencer: linear ramp generator with scan sequencing.
//
// Input stream (i_s_*): one beat per command. tuser carries the opcode
// (tick, scan, move); tdata carries scan_origin, end_pos and scan_ticks.
// Output stream (o_m_*): exactly one beat per input beat, carrying the
// position after the command, the mode, the moving flag and the
// scan_start / scan_done pulses.
// The APB port holds move_ticks at address 0 (reset value 500); write it
// only while the block is idle.
// Flow: scan, move, unknown, idle ticks and ticks that end a ramp go from
// accept through ST_PUT to the output register. A tick that interpolates
// runs |span| * count through a bit-serial multiplier (ST_MUL) and then a
// restoring divider (ST_DIV) before ST_PUT.
// One beat is in flight at a time; the next beat is taken as soon as the
// result is in the output register, even if that register still waits.
// A stalled receiver holds the output beat and, once a second result is
// ready, holds the input side too. Reset clears the angle, the ramp and
// the output valid flag; no clearing pass is needed.
module joint_ramp_scan_sequencer #(
    parameter int ANGLE_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // slave stream
    input  logic                                         i_s_tvalid,
    output logic                                         o_s_tready,
    // tdata: scan_origin, end_pos, scan_ticks (lowest first), zero padded
    input  logic [((2*ANGLE_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // tuser: opcode
    input  logic [1:0]                                   i_s_tuser,
    // master stream
    output logic                                         o_m_tvalid,
    input  logic                                         i_m_tready,
    // tdata: position, mode, moving, scan_start, scan_done (lowest first)
    output logic [((ANGLE_WIDTH+5+7)/8)*8-1:0]           o_m_tdata,
    // APB configuration
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [1:0]                                   paddr,
    input  logic [31:0]                                  pwdata,
    output logic [31:0]                                  prdata,
    output logic                                         pready
);
    import jrss_pkg::*;

    localparam int AW = ANGLE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int PW = AW + CW;
    localparam int OW = ((AW + 5 + 7) / 8) * 8;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [AW-1:0]       r_angle, n_angle;
    logic [AW-1:0]       r_origin, n_origin;
    logic [AW-1:0]       r_target, n_target;
    logic                r_span_neg, n_span_neg;
    logic [AW-1:0]       r_span_mag, n_span_mag;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_tgoal, n_tgoal;
    logic                r_active, n_active;
    logic [AW-1:0]       r_sweep_end, n_sweep_end;
    logic [CW-1:0]       r_sweep_ticks, n_sweep_ticks;
    logic [REG_WIDTH-1:0] r_move_ticks;
    logic                r_pulse_start, n_pulse_start;
    logic                r_pulse_done, n_pulse_done;
    logic                r_out_valid, n_out_valid;
    logic [OW-1:0]       r_out_data, n_out_data;

    logic [AW-1:0]       in_scan_origin;
    logic [AW-1:0]       in_end_pos;
    logic [CW-1:0]       in_scan_ticks;
    logic [CW:0]         cnt_inc;

    logic                ramp_load;
    logic [AW-1:0]       ramp_to;
    logic [AW-1:0]       ramp_from;
    logic [CW-1:0]       ramp_ticks;
    t_phase              ramp_phase;
    logic [AW:0]         ramp_diff;
    logic [AW:0]         ramp_abs;

    logic                mul_start;
    logic                mul_done;
    logic [PW-1:0]       mul_product;
    logic                div_start;
    logic                div_done;
    logic [AW-1:0]       div_quo;

    assign in_scan_origin = i_s_tdata[AW-1:0];
    assign in_end_pos     = i_s_tdata[2*AW-1:AW];
    assign in_scan_ticks  = i_s_tdata[2*AW+CW-1:2*AW];
    assign cnt_inc        = {1'b0, r_cnt} + 1'b1;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign pready     = 1'b1;
    assign prdata     = {{(32-REG_WIDTH){1'b0}}, r_move_ticks};

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_angle       = r_angle;
        n_origin      = r_origin;
        n_target      = r_target;
        n_span_neg    = r_span_neg;
        n_span_mag    = r_span_mag;
        n_cnt         = r_cnt;
        n_tgoal       = r_tgoal;
        n_active      = r_active;
        n_sweep_end   = r_sweep_end;
        n_sweep_ticks = r_sweep_ticks;
        n_pulse_start = r_pulse_start;
        n_pulse_done  = r_pulse_done;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_data    = r_out_data;
        ramp_load     = 1'b0;
        ramp_to       = in_end_pos;
        ramp_from     = r_angle;
        ramp_ticks    = CW'(r_move_ticks);
        ramp_phase    = PH_MOVE;
        mul_start     = 1'b0;
        div_start     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_pulse_start = 1'b0;
                    n_pulse_done  = 1'b0;
                    n_state       = ST_PUT;
                    case (i_s_tuser)
                        OP_SCAN: begin
                            n_sweep_end   = in_end_pos;
                            n_sweep_ticks = in_scan_ticks;
                            ramp_load     = 1'b1;
                            ramp_to       = in_scan_origin;
                            ramp_phase    = PH_TO_START;
                        end
                        OP_MOVE: begin
                            ramp_load = 1'b1;
                        end
                        OP_TICK: begin
                            if (r_active) begin
                                n_cnt = cnt_inc[CW-1:0];
                                if ({1'b0, r_tgoal} <= cnt_inc) begin
                                    // ramp ends: land exactly on the target
                                    n_angle  = r_target;
                                    n_cnt    = '0;
                                    n_tgoal  = '0;
                                    n_active = 1'b0;
                                    n_phase  = PH_IDLE;
                                    case (r_phase)
                                        PH_TO_START: begin
                                            n_pulse_start = 1'b1;
                                            ramp_load     = 1'b1;
                                            ramp_to       = r_sweep_end;
                                            ramp_from     = r_target;
                                            ramp_ticks    = r_sweep_ticks;
                                            ramp_phase    = PH_SCAN;
                                        end
                                        PH_SCAN: begin
                                            n_pulse_done = 1'b1;
                                        end
                                        default: ;
                                    endcase
                                end else begin
                                    mul_start = 1'b1;
                                    n_state   = ST_MUL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_angle = r_span_neg ? (r_origin - div_quo) : (r_origin + div_quo);
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OW'({r_pulse_done, r_pulse_start, r_active,
                                       r_phase, r_angle});
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        ramp_diff = {ramp_to[AW-1], ramp_to} - {ramp_from[AW-1], ramp_from};
        ramp_abs  = ramp_diff[AW] ? (~ramp_diff + 1'b1) : ramp_diff;

        if (ramp_load) begin
            n_target   = ramp_to;
            n_origin   = ramp_from;
            n_span_neg = ramp_diff[AW];
            n_span_mag = ramp_abs[AW-1:0];
            n_cnt      = '0;
            n_tgoal    = ramp_ticks;
            n_active   = 1'b1;
            n_phase    = ramp_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_IDLE;
            r_angle       <= '0;
            r_origin      <= '0;
            r_target      <= '0;
            r_span_neg    <= 1'b0;
            r_span_mag    <= '0;
            r_cnt         <= '0;
            r_tgoal       <= '0;
            r_active      <= 1'b0;
            r_sweep_end   <= '0;
            r_sweep_ticks <= '0;
            r_pulse_start <= 1'b0;
            r_pulse_done  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_move_ticks  <= MOVE_TICKS_RESET;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_angle       <= n_angle;
            r_origin      <= n_origin;
            r_target      <= n_target;
            r_span_neg    <= n_span_neg;
            r_span_mag    <= n_span_mag;
            r_cnt         <= n_cnt;
            r_tgoal       <= n_tgoal;
            r_active      <= n_active;
            r_sweep_end   <= n_sweep_end;
            r_sweep_ticks <= n_sweep_ticks;
            r_pulse_start <= n_pulse_start;
            r_pulse_done  <= n_pulse_done;
            r_out_valid   <= n_out_valid;
            if (psel && penable && pwrite && (paddr == ADDR_MOVE_TICKS)) begin
                r_move_ticks <= pwdata[REG_WIDTH-1:0];
            end
        end
    end

    // |span| * count, then divided by the tick goal (count < goal here)
    jrss_mul #(
        .AW (AW),
        .CW (CW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (r_span_mag),
        .i_mplr    (cnt_inc[CW-1:0]),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    jrss_div #(
        .DW (PW),
        .CW (CW),
        .QW (AW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_product),
        .i_divisor  (r_tgoal),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

endmodule

// ===== dv/tb_joint_ramp_scan_sequencer.sv =====
// Self-checking testbench for the joint ramp scan sequencer: directed table, then random phases.
module tb_joint_ramp_scan_sequencer;
    import jrss_pkg::*;

    localparam logic [1:0] OP_UNKNOWN    = 2'd3;
    localparam int        N_DIR          = 25;
    localparam int        N_PHASES       = 5;
    localparam int        ITEMS_PER_PHASE = 150;
    localparam int        HOLD_CYCLES    = 400;
    localparam int        DRAIN_CYCLES   = 60;

    typedef struct {
        logic [15:0] pos;
        logic [1:0]  mode;
        logic        moving;
        logic        sstart;
        logic        sdone;
    } joint_beat_t;

    typedef struct {
        bit          is_cfg;
        logic [15:0] ticks;
        logic [1:0]  op;
        logic [15:0] sp;
        logic [15:0] ep;
        logic [15:0] st;
        bit          typed;
        logic [15:0] w_pos;
        logic [1:0]  w_mode;
        logic        w_mov;
        logic        w_ss;
        logic        w_sd;
    } dir_row_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // tdata: scan_origin, end_pos, scan_ticks (lowest first)
    logic [47:0] i_s_tdata  = '0;
    // tuser: opcode
    logic [1:0]  i_s_tuser  = OP_TICK;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // tdata: position, mode, moving, scan_start, scan_done (lowest first)
    logic [23:0] o_m_tdata;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [1:0]  paddr      = ADDR_MOVE_TICKS;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    joint_ramp_scan_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    // joint model state
    logic signed [15:0] jt_angle      = '0;
    logic signed [15:0] jt_target     = '0;
    logic signed [15:0] jt_sweep_end  = '0;
    logic        [15:0] jt_sweep_ticks = '0;
    logic        [15:0] jt_move_ticks = MOVE_TICKS_RESET;
    longint             jt_origin     = 0;
    longint             jt_span       = 0;
    longint             jt_count      = 0;
    longint             jt_limit      = 0;
    bit                 jt_active     = 1'b0;
    t_phase             jt_phase      = PH_IDLE;

    joint_beat_t joint_exp_q[$];
    int          mismatch_count = 0;
    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;
    bit          rx_hold        = 1'b0;
    int          hold_cnt       = 0;

    dir_row_t dir_rows [N_DIR] = '{
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_MOVE,    16'h0000, 16'h7FFF, 16'h0000, 1, 16'h0000, PH_MOVE, 1, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{1, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_SCAN,    16'h8000, 16'h7FFF, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 1, 16'h7FFF, PH_IDLE, 0, 0, 1},
        '{0, 16'd0,    OP_MOVE,    16'h0000, 16'h8000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{1, 16'd3,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_SCAN,    16'h7FFF, 16'h8000, 16'hFFFF, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_MOVE,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_UNKNOWN, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{1, 16'hFFFF, OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_MOVE,    16'h0000, 16'h8000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0},
        '{0, 16'd0,    OP_TICK,    16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, PH_IDLE, 0, 0, 0}
    };

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h want %0h", what, got, want);
        mismatch_count++;
    endtask

    function automatic void load_ramp(logic signed [15:0] target, logic [15:0] ticks,
                                      t_phase ph);
        jt_target = target;
        jt_origin = longint'(jt_angle);
        jt_span   = longint'(target) - longint'(jt_angle);
        jt_count  = 0;
        jt_limit  = longint'(ticks);
        jt_active = 1'b1;
        jt_phase  = ph;
    endfunction

    function automatic joint_beat_t step_joint(logic [1:0] op, logic [15:0] sp,
                                               logic [15:0] ep, logic [15:0] st);
        joint_beat_t b;
        longint      mag;
        longint      q;
        b.sstart = 1'b0;
        b.sdone  = 1'b0;
        case (op)
            OP_SCAN: begin
                jt_sweep_end   = ep;
                jt_sweep_ticks = st;
                load_ramp(sp, jt_move_ticks, PH_TO_START);
            end
            OP_MOVE: load_ramp(ep, jt_move_ticks, PH_MOVE);
            OP_TICK: if (jt_active) begin
                jt_count++;
                if (jt_limit <= jt_count) begin
                    jt_angle  = jt_target;
                    jt_count  = 0;
                    jt_limit  = 0;
                    jt_active = 1'b0;
                    if (jt_phase == PH_TO_START) begin
                        b.sstart = 1'b1;
                        load_ramp(jt_sweep_end, jt_sweep_ticks, PH_SCAN);
                    end else begin
                        b.sdone  = (jt_phase == PH_SCAN);
                        jt_phase = PH_IDLE;
                    end
                end else begin
                    // magnitude first so the quotient truncates toward zero
                    mag = (jt_span < 0) ? -jt_span : jt_span;
                    q   = (mag * jt_count) / jt_limit;
                    jt_angle = 16'((jt_span < 0) ? jt_origin - q : jt_origin + q);
                end
            end
            default: ;
        endcase
        b.pos    = jt_angle;
        b.mode   = jt_phase;
        b.moving = jt_active;
        return b;
    endfunction

    task automatic send_item(logic [1:0] op, logic [15:0] sp, logic [15:0] ep,
                             logic [15:0] st, bit typed, joint_beat_t typed_want);
        joint_beat_t want;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {st, ep, sp};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        want = step_joint(op, sp, ep, st);
        if (typed) want = typed_want;
        joint_exp_q.push_back(want);
    endtask

    task automatic write_move_ticks(logic [15:0] ticks);
        i_s_tvalid <= 1'b0;
        while (joint_exp_q.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MOVE_TICKS;
        pwdata  <= {16'd0, ticks};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        jt_move_ticks = ticks;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== ticks) report_mismatch("move_ticks readback", prdata[15:0], ticks);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver: random stalls, or one long hold-off counted here
    always @(posedge i_clk) begin
        if (!rx_hold) begin
            hold_cnt   <= 0;
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end else if (hold_cnt < HOLD_CYCLES) begin
            hold_cnt   <= hold_cnt + 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : beat_check
        joint_beat_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (joint_exp_q.size() == 0) begin
                report_mismatch("beat with nothing expected", o_m_tdata, 0);
            end else begin
                want = joint_exp_q.pop_front();
                if (o_m_tdata[15:0] !== want.pos)
                    report_mismatch("position", o_m_tdata[15:0], want.pos);
                if (o_m_tdata[17:16] !== want.mode)
                    report_mismatch("mode", o_m_tdata[17:16], want.mode);
                if (o_m_tdata[18] !== want.moving)
                    report_mismatch("moving", o_m_tdata[18], want.moving);
                if (o_m_tdata[19] !== want.sstart)
                    report_mismatch("scan_start", o_m_tdata[19], want.sstart);
                if (o_m_tdata[20] !== want.sdone)
                    report_mismatch("scan_done", o_m_tdata[20], want.sdone);
            end
        end
    end

    initial begin
        joint_beat_t typed_want;
        joint_beat_t no_want;
        int          r;
        logic [1:0]  op;
        logic [15:0] st;
        logic [15:0] ticks;
        no_want = '{16'd0, 2'd0, 1'b0, 1'b0, 1'b0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                write_move_ticks(dir_rows[n].ticks);
            end else begin
                typed_want = '{dir_rows[n].w_pos, dir_rows[n].w_mode, dir_rows[n].w_mov,
                               dir_rows[n].w_ss, dir_rows[n].w_sd};
                send_item(dir_rows[n].op, dir_rows[n].sp, dir_rows[n].ep, dir_rows[n].st,
                          dir_rows[n].typed, typed_want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin ticks = 16'd4;                     tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin ticks = 16'd0;                     tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin ticks = 16'($urandom_range(1, 10)); tx_idle_pct = 0;  rx_stall_pct = 81; end
                3: begin ticks = 16'hFFFF;                  tx_idle_pct = 17; rx_stall_pct = 17; end
                default: begin ticks = 16'd2;               tx_idle_pct = 0;  rx_stall_pct = 0;  end
            endcase
            write_move_ticks(ticks);
            rx_hold = (ph == N_PHASES - 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r  = $urandom_range(99);
                op = (r < 70) ? OP_TICK : (r < 82) ? OP_SCAN : (r < 95) ? OP_MOVE : OP_UNKNOWN;
                // mostly short sweeps so scans run through to the end
                st = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(12));
                send_item(op, 16'($urandom), 16'($urandom), st, 1'b0, no_want);
            end
        end

        i_s_tvalid <= 1'b0;
        while (joint_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && joint_exp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
